[rtl/core/tsbb_pkg.sv]
package tsbb_pkg;

    // Frame and texture geometry.
    localparam int FB_WIDTH     = 640;
    localparam int FB_HEIGHT    = 480;
    localparam int TEX_MAX_DIM  = 64;
    localparam int BORDER_WIDTH = 2;

    // Texel store.
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int TEXEL_W     = 24;

    // Width of the texture size registers.
    localparam int TEX_DIM_W = 7;

    // The scale quotient is below the texture size, so it needs log2 of the
    // largest texture size in bits. The dividend holds dx times texture size.
    localparam int QUO_W = $clog2(TEX_MAX_DIM);
    localparam int REM_W = 17;

    // Default queue depths.
    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 16;

    // Operation codes of an input transaction.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Register indexes on the configuration channel.
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_BAR_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_BAR_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_FILL_WIDTH = 3'd4;
    localparam logic [2:0] CFG_TINT_RGB   = 3'd5;
    localparam logic [2:0] CFG_TEX_WIDTH  = 3'd6;
    localparam logic [2:0] CFG_TEX_HEIGHT = 3'd7;

    // Live configuration, texture sizes already saturated.
    typedef struct packed {
        logic signed [10:0]          origin_x;
        logic signed [10:0]          origin_y;
        logic [9:0]                  bar_width;
        logic [8:0]                  bar_height;
        logic [9:0]                  fill_width;
        logic [23:0]                 tint_rgb;
        logic [TEX_DIM_W-1:0]        tex_width;
        logic [TEX_DIM_W-1:0]        tex_height;
    } tsbb_cfg_t;

    // One classified transaction as it travels from front to back.
    typedef struct packed {
        logic                op;
        logic                write_valid;
        logic                border;
        logic                half_tint;
        logic [9:0]          fb_column;
        logic [8:0]          fb_row;
        logic [9:0]          dx;
        logic [8:0]          dy;
        logic [STORE_AW-1:0] addr;
        logic [TEXEL_W-1:0]  texel;
    } tsbb_item_t;

    // One result transaction.
    typedef struct packed {
        logic       write_valid;
        logic [9:0] fb_column;
        logic [8:0] fb_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tsbb_result_t;

endpackage

[rtl/core/tsbb_ram.sv]
module tsbb_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tsbb_fifo.sv]
module tsbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/core/tsbb_front.sv]
module tsbb_front import tsbb_pkg::*; (
    input  tsbb_cfg_t  cfg,
    input  logic       operation,
    input  logic [11:0] texel_addr,
    input  logic [7:0] texel_red,
    input  logic [7:0] texel_green,
    input  logic [7:0] texel_blue,
    input  logic [9:0] pixel_dx,
    input  logic [8:0] pixel_dy,
    output tsbb_item_t item
);

    logic signed [11:0] scr_x;
    logic signed [11:0] scr_y;
    logic               sizes_ok;
    logic               in_bar;
    logic               in_frame;
    logic               near_edge;

    always_comb begin
        scr_x = $signed({cfg.origin_x[10], cfg.origin_x}) + $signed({2'b00, pixel_dx});
        scr_y = $signed({cfg.origin_y[10], cfg.origin_y}) + $signed({3'b000, pixel_dy});

        sizes_ok = (cfg.bar_width != '0) && (cfg.bar_height != '0) &&
                   (cfg.tex_width != '0) && (cfg.tex_height != '0);
        in_bar   = (pixel_dx < cfg.bar_width) && (pixel_dy < cfg.bar_height);
        in_frame = !scr_x[11] && (scr_x[10:0] < 11'(FB_WIDTH)) &&
                   !scr_y[11] && (scr_y[10:0] < 11'(FB_HEIGHT));

        // The border rows and columns lie within BORDER_WIDTH of any bar edge.
        near_edge = (pixel_dy < 9'(BORDER_WIDTH)) ||
                    (({1'b0, pixel_dy} + 10'(BORDER_WIDTH)) >= {1'b0, cfg.bar_height}) ||
                    (pixel_dx < 10'(BORDER_WIDTH)) ||
                    (({1'b0, pixel_dx} + 11'(BORDER_WIDTH)) >= {1'b0, cfg.bar_width});

        item.op          = operation;
        item.write_valid = (operation == OP_PIXEL) && sizes_ok && in_bar && in_frame;
        item.border      = near_edge;
        item.half_tint   = (pixel_dx >= cfg.fill_width);
        item.fb_column   = scr_x[9:0];
        item.fb_row      = 9'(FB_HEIGHT - 1) - scr_y[8:0];
        item.dx          = pixel_dx;
        item.dy          = pixel_dy;
        item.addr        = texel_addr[STORE_AW-1:0];
        item.texel       = {texel_red, texel_green, texel_blue};
    end

endmodule

[rtl/core/tsbb_back.sv]
module tsbb_back import tsbb_pkg::*; #(
    parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  tsbb_cfg_t    cfg,
    input  logic         head_valid,
    output logic         head_ready,
    input  tsbb_item_t   head_item,
    input  logic         res_release,
    output logic         res_valid,
    output tsbb_result_t res
);

    localparam int RSV_W  = $clog2(OUT_DEPTH + 1);
    localparam int LIN_W  = QUO_W + TEX_DIM_W + 1;

    function automatic logic [7:0] shade_div(input logic [15:0] prod);
        logic [16:0] biased;
        logic [16:0] approx;
        biased = {1'b0, prod} + 17'd127;
        approx = biased + (biased >> 8) + 17'd1;
        return approx[15:8];
    endfunction

    // Output queue space reserved for pixels in flight.
    logic [RSV_W-1:0] reserved_reg, reserved_next;
    logic             issue_pixel;

    // Scale division pipeline, stage 0 holds the products.
    logic             dv_reg  [0:QUO_W];
    tsbb_item_t       dit_reg [0:QUO_W];
    logic [REM_W-1:0] rx_reg  [0:QUO_W];
    logic [REM_W-1:0] ry_reg  [0:QUO_W];
    logic [QUO_W-1:0] qx_reg  [0:QUO_W];
    logic [QUO_W-1:0] qy_reg  [0:QUO_W];
    logic [REM_W-1:0] dsx     [QUO_W];
    logic [REM_W-1:0] dsy     [QUO_W];
    logic             gx      [QUO_W];
    logic             gy      [QUO_W];

    // Address, store read and shading stages.
    logic                a_v_reg;
    tsbb_item_t          a_item_reg;
    logic [STORE_AW-1:0] a_addr_reg;
    logic [LIN_W-1:0]    lin_addr;
    logic                r_v_reg;
    tsbb_item_t          r_item_reg;
    logic [TEXEL_W-1:0]  texel;
    logic [23:0]         tint_sel;
    logic                m_v_reg;
    tsbb_item_t          m_item_reg;
    logic [15:0]         m_pr_reg;
    logic [15:0]         m_pg_reg;
    logic [15:0]         m_pb_reg;
    logic                shaded;

    assign head_ready  = (head_item.op == OP_LOAD) || (reserved_reg < RSV_W'(OUT_DEPTH));
    assign issue_pixel = head_valid && head_ready && (head_item.op == OP_PIXEL);

    always_comb begin
        reserved_next = reserved_reg + RSV_W'(issue_pixel) - RSV_W'(res_release);
    end

    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            dsx[j] = REM_W'(cfg.bar_width) << (QUO_W - 1 - j);
            dsy[j] = REM_W'(cfg.bar_height) << (QUO_W - 1 - j);
            gx[j]  = (rx_reg[j] >= dsx[j]);
            gy[j]  = (ry_reg[j] >= dsy[j]);
        end
        lin_addr = LIN_W'(qy_reg[QUO_W]) * LIN_W'(cfg.tex_width) + LIN_W'(qx_reg[QUO_W]);
        tint_sel = r_item_reg.half_tint ? ((cfg.tint_rgb >> 1) & 24'h7F7F7F) : cfg.tint_rgb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
            for (int j = 0; j <= QUO_W; j++) begin
                dv_reg[j] <= 1'b0;
            end
            a_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
        end else begin
            reserved_reg <= reserved_next;
            dv_reg[0]    <= head_valid && head_ready;
            for (int j = 0; j < QUO_W; j++) begin
                dv_reg[j+1] <= dv_reg[j];
            end
            a_v_reg <= dv_reg[QUO_W];
            r_v_reg <= a_v_reg && (a_item_reg.op == OP_PIXEL);
            m_v_reg <= r_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dit_reg[0] <= head_item;
        rx_reg[0]  <= REM_W'(head_item.dx) * REM_W'(cfg.tex_width);
        ry_reg[0]  <= REM_W'(head_item.dy) * REM_W'(cfg.tex_height);
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
        // One quotient bit per stage, most significant first.
        for (int j = 0; j < QUO_W; j++) begin
            dit_reg[j+1] <= dit_reg[j];
            rx_reg[j+1]  <= gx[j] ? rx_reg[j] - dsx[j] : rx_reg[j];
            ry_reg[j+1]  <= gy[j] ? ry_reg[j] - dsy[j] : ry_reg[j];
            qx_reg[j+1]  <= {qx_reg[j][QUO_W-2:0], gx[j]};
            qy_reg[j+1]  <= {qy_reg[j][QUO_W-2:0], gy[j]};
        end
        a_item_reg <= dit_reg[QUO_W];
        a_addr_reg <= (dit_reg[QUO_W].op == OP_PIXEL) ? lin_addr[STORE_AW-1:0] :
                                                        dit_reg[QUO_W].addr;
        r_item_reg <= a_item_reg;
        m_item_reg <= r_item_reg;
        m_pr_reg   <= 16'(texel[23:16]) * 16'(tint_sel[23:16]);
        m_pg_reg   <= 16'(texel[15:8]) * 16'(tint_sel[15:8]);
        m_pb_reg   <= 16'(texel[7:0]) * 16'(tint_sel[7:0]);
    end

    tsbb_ram #(
        .DATA_W (TEXEL_W),
        .DEPTH  (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (a_v_reg && (a_item_reg.op == OP_LOAD)),
        .wr_addr (a_addr_reg),
        .wr_data (a_item_reg.texel),
        .rd_addr (a_addr_reg),
        .rd_data (texel)
    );

    always_comb begin
        shaded          = m_item_reg.write_valid && !m_item_reg.border;
        res_valid       = m_v_reg;
        res.write_valid = m_item_reg.write_valid;
        res.fb_column   = m_item_reg.write_valid ? m_item_reg.fb_column : '0;
        res.fb_row      = m_item_reg.write_valid ? m_item_reg.fb_row : '0;
        res.red         = shaded ? shade_div(m_pr_reg) : '0;
        res.green       = shaded ? shade_div(m_pg_reg) : '0;
        res.blue        = shaded ? shade_div(m_pb_reg) : '0;
    end

endmodule

[rtl/core/tinted_scaled_bar_blitter.sv]
// An accepted input transaction passes the input queue, the scale divider and the address,
// store read and shading stages before its result enters the output queue; texel loads give no result.
// Throughput: one transaction per cycle; the scale divider and texel store are pipelined
// and only a full output queue reservation (a stalled m_ready) holds back pixel requests.
// Reset: aresetn is synchronous and active low; it clears the queues and restores the
// register defaults. The texel store is not cleared and must be loaded before use.
module tinted_scaled_bar_blitter import tsbb_pkg::*; #(
    parameter int IN_DEPTH  = IN_QUEUE_DEPTH,
    parameter int OUT_DEPTH = OUT_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    // Input channel: texel loads and pixel requests.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [11:0] s_texel_addr,
    input  logic [7:0]  s_texel_red,
    input  logic [7:0]  s_texel_green,
    input  logic [7:0]  s_texel_blue,
    input  logic [9:0]  s_pixel_dx,
    input  logic [8:0]  s_pixel_dy,

    // Result channel: one transaction per pixel request.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_valid,
    output logic [9:0]  m_fb_column,
    output logic [8:0]  m_fb_row,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue
);

    logic signed [10:0]   origin_x_reg;
    logic signed [10:0]   origin_y_reg;
    logic [9:0]           bar_width_reg;
    logic [8:0]           bar_height_reg;
    logic [9:0]           fill_width_reg;
    logic [23:0]          tint_rgb_reg;
    logic [TEX_DIM_W-1:0] tex_width_reg;
    logic [TEX_DIM_W-1:0] tex_height_reg;

    tsbb_cfg_t    cfg;
    tsbb_item_t   front_item;
    logic         head_valid;
    logic         head_ready;
    tsbb_item_t   head_item;
    logic         res_valid;
    tsbb_result_t res;
    tsbb_result_t out_res;

    // Registers accept a write in every cycle. The host is to write them only while the block
    // is idle, so that no transaction in flight sees a change; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            bar_width_reg  <= 10'd109;
            bar_height_reg <= 9'd9;
            fill_width_reg <= '0;
            tint_rgb_reg   <= 24'hB4191D;
            tex_width_reg  <= TEX_DIM_W'(TEX_MAX_DIM);
            tex_height_reg <= TEX_DIM_W'(TEX_MAX_DIM);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg   <= $signed(cfg_data[10:0]);
                CFG_ORIGIN_Y:   origin_y_reg   <= $signed(cfg_data[10:0]);
                CFG_BAR_WIDTH:  bar_width_reg  <= cfg_data[9:0];
                CFG_BAR_HEIGHT: bar_height_reg <= cfg_data[8:0];
                CFG_FILL_WIDTH: fill_width_reg <= cfg_data[9:0];
                CFG_TINT_RGB:   tint_rgb_reg   <= cfg_data;
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data[TEX_DIM_W-1:0];
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_data[TEX_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Texture sizes beyond the largest supported texture saturate.
    always_comb begin
        cfg.origin_x   = origin_x_reg;
        cfg.origin_y   = origin_y_reg;
        cfg.bar_width  = bar_width_reg;
        cfg.bar_height = bar_height_reg;
        cfg.fill_width = fill_width_reg;
        cfg.tint_rgb   = tint_rgb_reg;
        cfg.tex_width  = (tex_width_reg > TEX_DIM_W'(TEX_MAX_DIM)) ?
                         TEX_DIM_W'(TEX_MAX_DIM) : tex_width_reg;
        cfg.tex_height = (tex_height_reg > TEX_DIM_W'(TEX_MAX_DIM)) ?
                         TEX_DIM_W'(TEX_MAX_DIM) : tex_height_reg;
    end

    // The front classifies each transaction: bar and frame clipping, the border,
    // the tint half and the framebuffer coordinates are all settled here.
    tsbb_front u_front (
        .cfg         (cfg),
        .operation   (s_operation),
        .texel_addr  (s_texel_addr),
        .texel_red   (s_texel_red),
        .texel_green (s_texel_green),
        .texel_blue  (s_texel_blue),
        .pixel_dx    (s_pixel_dx),
        .pixel_dy    (s_pixel_dy),
        .item        (front_item)
    );

    // A short queue decouples the front from the back pipeline.
    tsbb_fifo #(
        .WIDTH ($bits(tsbb_item_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (front_item),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_data  (head_item)
    );

    // The back pipeline never stalls. It issues a pixel request only when the
    // output queue has a free entry reserved for it, and it performs texel loads
    // in order with the store reads so that a load is seen by later requests.
    tsbb_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head_ready  (head_ready),
        .head_item   (head_item),
        .res_release (m_valid && m_ready),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output queue; the reservation in the back keeps it from overflowing.
    tsbb_fifo #(
        .WIDTH ($bits(tsbb_result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_write_valid = out_res.write_valid;
    assign m_fb_column   = out_res.fb_column;
    assign m_fb_row      = out_res.fb_row;
    assign m_out_red     = out_res.red;
    assign m_out_green   = out_res.green;
    assign m_out_blue    = out_res.blue;

endmodule
